/* design/tunnel_id_allocator_table_defines.svh */
// Assertion macros of the tunnel ID allocator top level.
`ifndef TUNNEL_ID_ALLOCATOR_TABLE_DEFINES_SVH
`define TUNNEL_ID_ALLOCATOR_TABLE_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define TIAT_ASSERT_IMPL(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("tunnel ID allocator check failed");

// Condition a implies condition b in the following cycle.
`define TIAT_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("tunnel ID allocator check failed");

`endif

/* design/tiat_pkg.sv */
// Types, constants and helpers of the tunnel ID allocator.
package tiat_pkg;

	localparam int TIAT_NUM_PEERS = 16;
	localparam int TIAT_ADDR_W = 3;
	localparam int TIAT_RANGE_SHIFT = 24;
	localparam logic [3:0] TIAT_RANGE_FIELD_BITS = 4'd8;
	localparam logic [31:0] TIAT_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] TIAT_FIRST_ID = 32'h0000_0001;

	// Register index of the node role.
	localparam logic [TIAT_ADDR_W-3:0] TIAT_REG_NODE_ROLE = '0;

	typedef enum logic [1:0] {
		TIAT_FUNC_SET_RANGE = 2'd0,
		TIAT_FUNC_ALLOCATE  = 2'd1,
		TIAT_FUNC_DELETE    = 2'd2,
		TIAT_FUNC_UNUSED    = 2'd3
	} tiat_func_t;

	typedef enum logic [1:0] {
		TIAT_ST_OK        = 2'd0,
		TIAT_ST_NOT_FOUND = 2'd1,
		TIAT_ST_FULL      = 2'd2
	} tiat_status_t;

	typedef enum logic [1:0] {
		TIAT_ROLE_SGW      = 2'd0,
		TIAT_ROLE_COMBINED = 2'd1,
		TIAT_ROLE_PGW      = 2'd2
	} tiat_role_t;

	typedef enum logic [1:0] {
		TIAT_IDLE,
		TIAT_SCAN,
		TIAT_EXEC,
		TIAT_FIN
	} tiat_state_t;

	typedef struct packed {
		logic        is_v6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  range_byte;
		logic [31:0] base;
		logic [31:0] offset;
		logic [31:0] mask;
		logic [31:0] last_id;
	} tiat_rec_t;

	function automatic logic [31:0] tiat_current_id(tiat_rec_t rec);
		return (rec.last_id & rec.mask) | {rec.range_byte, 24'h0};
	endfunction

endpackage

/* design/tiat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tiat_ram import tiat_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = TIAT_NUM_PEERS
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/tunnel_id_allocator_table.sv */
// Top level of the per-peer tunnel ID allocator: sequencer, peer table and APB register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall   | func ip_is_v6 addr_hi addr_lo range_bits
//           |           |                      | range_value pgw_side
//   out     | output    | out_valid / out_stall | teid status
//   apb     | input     | psel penable pwrite   | paddr pwdata prdata pready
//
// An item passes the key search, then EXEC and FIN before its result is loaded; the peer
// table has one read port and the key search reads one entry a cycle, stopping at the first
// match. Reset clears the valid bits at once, so the table needs no clearing pass. in_stall
// is high from the input beat until the result has been loaded; the result register then
// holds while out_stall is high and the next beat may already be accepted.
`include "tunnel_id_allocator_table_defines.svh"

module tunnel_id_allocator_table import tiat_pkg::*; #(
	parameter int NUM_PEERS = TIAT_NUM_PEERS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             func,
	input  logic                   ip_is_v6,
	input  logic [63:0]            addr_hi,
	input  logic [63:0]            addr_lo,
	input  logic [3:0]             range_bits,
	input  logic [7:0]             range_value,
	input  logic                   pgw_side,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [31:0]            teid,
	output logic [1:0]             status,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [TIAT_ADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int IW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PEERS - 1);

	tiat_state_t state_q, state_d;

	// Configuration register.
	logic [1:0] node_role_q;

	// Captured input item.
	tiat_func_t it_func_q;
	logic        it_v6_q;
	logic [63:0] it_hi_q;
	logic [63:0] it_lo_q;
	logic [3:0]  it_rbits_q;
	logic [7:0]  it_rval_q;
	logic        it_pgw_q;

	// Search control.
	logic [NUM_PEERS-1:0] valid_q;
	logic [IW-1:0] scan_q;
	logic          issuing_q;
	logic          cmp_v_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	// Work record and pending result.
	tiat_rec_t    rec_q;
	tiat_rec_t    rec_d;
	tiat_rec_t    rdata;
	logic         wr_q;
	logic         wr_d;
	logic [IW-1:0] slot_q;
	logic         zero_q;
	logic         zero_d;
	tiat_status_t stat_q;
	tiat_status_t stat_d;

	logic         out_valid_q;
	logic [31:0]  teid_q;
	tiat_status_t status_q;

	logic in_beat;
	logic match;
	logic scan_hit;
	logic scan_miss;
	logic out_load;
	logic ram_we;

	// Range settings.
	logic [3:0]  rb;
	logic [3:0]  rsh;
	logic [7:0]  new_rbyte;
	logic        serves;

	tiat_rec_t new_rec;

	tiat_ram #(
		.WIDTH($bits(tiat_rec_t)),
		.DEPTH(NUM_PEERS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(rec_q),
		.raddr(scan_q),
		.rdata(rdata)
	);

	// APB register.
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[TIAT_ADDR_W-1:2] == TIAT_REG_NODE_ROLE) begin
			prdata = {30'h0, node_role_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_role_q <= TIAT_ROLE_SGW;
		end else if (psel && penable && pwrite && pready &&
			     paddr[TIAT_ADDR_W-1:2] == TIAT_REG_NODE_ROLE) begin
			node_role_q <= pwdata[1:0];
		end
	end

	// Key compare against the entry read in the previous cycle.
	always_comb begin
		match = valid_q[cmp_idx_s1] && (rdata.is_v6 == it_v6_q) &&
			(rdata.addr_low[31:0] == it_lo_q[31:0]);
		if (it_v6_q) begin
			match = match && (rdata.addr_low[63:32] == it_lo_q[63:32]) &&
				(rdata.addr_high == it_hi_q);
		end
	end

	assign scan_hit  = (state_q == TIAT_SCAN) && cmp_v_s1 && match;
	assign scan_miss = (state_q == TIAT_SCAN) && cmp_v_s1 && !match && (cmp_idx_s1 == LAST_IDX);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			TIAT_IDLE: begin
				if (in_valid) begin
					state_d = TIAT_SCAN;
				end
			end
			TIAT_SCAN: begin
				if (scan_hit || scan_miss) begin
					state_d = TIAT_EXEC;
				end
			end
			TIAT_EXEC: state_d = TIAT_FIN;
			TIAT_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = TIAT_IDLE;
				end
			end
			default: state_d = TIAT_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			TIAT_IDLE: in_stall = 1'b0;
			TIAT_FIN:  out_load = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
				out_load = 1'b0;
			end
		endcase
	end

	assign in_beat = in_valid && !in_stall;
	assign ram_we  = out_load && wr_q;

	// Operation datapath.
	always_comb begin
		rb        = (it_rbits_q > TIAT_RANGE_FIELD_BITS) ? TIAT_RANGE_FIELD_BITS : it_rbits_q;
		rsh       = TIAT_RANGE_FIELD_BITS - rb;
		new_rbyte = it_rval_q << rsh;
		serves    = it_pgw_q ? (node_role_q == TIAT_ROLE_PGW) :
			(node_role_q == TIAT_ROLE_SGW || node_role_q == TIAT_ROLE_COMBINED);

		new_rec            = '0;
		new_rec.is_v6      = it_v6_q;
		new_rec.addr_high  = it_v6_q ? it_hi_q : 64'h0;
		new_rec.addr_low   = it_v6_q ? it_lo_q : {32'h0, it_lo_q[31:0]};
		new_rec.range_byte = 8'h0;
		new_rec.base       = TIAT_FIRST_ID;
		new_rec.offset     = 32'h0;
		new_rec.mask       = TIAT_ALL_ONES;
		new_rec.last_id    = TIAT_FIRST_ID;

		rec_d  = rec_q;
		wr_d   = 1'b0;
		zero_d = 1'b1;
		stat_d = TIAT_ST_OK;
		case (it_func_q)
			TIAT_FUNC_SET_RANGE: begin
				if (!hit_q && !free_found_q) begin
					stat_d = TIAT_ST_FULL;
				end else begin
					if (!hit_q) begin
						rec_d = new_rec;
					end
					if (it_rbits_q != 4'd0) begin
						rec_d.range_byte = new_rbyte;
						rec_d.mask       = TIAT_ALL_ONES >> rb;
						rec_d.base       = {new_rbyte, 23'h0, new_rbyte == 8'h0};
					end
					wr_d   = 1'b1;
					zero_d = 1'b0;
				end
			end
			TIAT_FUNC_ALLOCATE: begin
				if (!hit_q) begin
					stat_d = TIAT_ST_NOT_FOUND;
				end else begin
					if (serves) begin
						rec_d.last_id = rec_q.base + rec_q.offset;
						rec_d.offset  = (rec_q.offset >= rec_q.mask) ? 32'h0 :
							rec_q.offset + 32'h1;
						wr_d = 1'b1;
					end
					zero_d = 1'b0;
				end
			end
			TIAT_FUNC_DELETE: begin
				if (!hit_q) begin
					stat_d = TIAT_ST_NOT_FOUND;
				end
			end
			default: begin
				stat_d = TIAT_ST_OK;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= TIAT_IDLE;
			valid_q      <= '0;
			scan_q       <= '0;
			issuing_q    <= 1'b0;
			cmp_v_s1     <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			wr_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= (state_q == TIAT_SCAN) && issuing_q;

			if (in_beat) begin
				scan_q       <= '0;
				issuing_q    <= 1'b1;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == TIAT_SCAN) begin
				if (issuing_q) begin
					if (!valid_q[scan_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (scan_q != LAST_IDX) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				if (scan_hit || (issuing_q && scan_q == LAST_IDX)) begin
					issuing_q <= 1'b0;
				end
				if (scan_hit) begin
					hit_q <= 1'b1;
				end
			end

			if (state_q == TIAT_EXEC) begin
				wr_q <= wr_d;
				if (it_func_q == TIAT_FUNC_DELETE && hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end

			if (ram_we) begin
				valid_q[slot_q] <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			it_func_q  <= tiat_func_t'(func);
			it_v6_q    <= ip_is_v6;
			it_hi_q    <= addr_hi;
			it_lo_q    <= addr_lo;
			it_rbits_q <= range_bits;
			it_rval_q  <= range_value;
			it_pgw_q   <= pgw_side;
		end
		if (state_q == TIAT_SCAN && issuing_q) begin
			cmp_idx_s1 <= scan_q;
			if (!valid_q[scan_q] && !free_found_q) begin
				free_idx_q <= scan_q;
			end
		end
		if (scan_hit) begin
			hit_idx_q <= cmp_idx_s1;
			rec_q     <= rdata;
		end
		if (state_q == TIAT_EXEC) begin
			rec_q  <= rec_d;
			zero_q <= zero_d;
			stat_q <= stat_d;
			slot_q <= hit_q ? hit_idx_q : free_idx_q;
		end
		if (out_load) begin
			teid_q   <= zero_q ? 32'h0 : tiat_current_id(rec_q);
			status_q <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign teid      = teid_q;
	assign status    = status_q;

	// A result that fails carries no tunnel ID.
	`TIAT_ASSERT_IMPL(a_fail_zero_teid, out_valid_q && status_q != TIAT_ST_OK, teid_q == 32'h0)
	// An input beat always starts a key search.
	`TIAT_ASSERT_NEXT(a_beat_starts_scan, in_beat, state_q == TIAT_SCAN)
	// Loading the result leaves it presented.
	`TIAT_ASSERT_NEXT(a_load_shows_result, out_load, out_valid_q)
	// A hit is only taken on an entry that is in use.
	`TIAT_ASSERT_IMPL(a_hit_on_valid, scan_hit, valid_q[cmp_idx_s1])

endmodule

/* bench/tb_tunnel_id_allocator_table.sv */
// Self-checking testbench for the tunnel ID allocator table.
module tb_tunnel_id_allocator_table;
	import tiat_pkg::*;

	localparam int NUM_PEERS = TIAT_NUM_PEERS;
	localparam int KEY_POOL = 24;
	localparam int PHASE_ITEMS = 300;
	localparam logic [TIAT_ADDR_W-1:0] ROLE_ADDR = {TIAT_REG_NODE_ROLE, 2'b00};
	// A role code outside the defined set; it serves neither allocation side.
	localparam logic [1:0] ROLE_NONE = 2'd3;

	typedef struct {
		tiat_func_t  op;
		logic        v6;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [3:0]  rbits;
		logic [7:0]  rval;
		logic        pgw;
	} peer_req_t;

	typedef struct packed {
		logic [31:0]  teid;
		tiat_status_t status;
	} teid_answer_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic ip_is_v6;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic [3:0] range_bits;
	logic [7:0] range_value;
	logic pgw_side;
	logic out_valid;
	logic out_stall;
	logic [31:0] teid;
	logic [1:0] status;
	logic psel;
	logic penable;
	logic pwrite;
	logic [TIAT_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the peer table and the role register.
	logic [1:0]  node_role_model;
	logic        slot_used [NUM_PEERS];
	logic        slot_v6 [NUM_PEERS];
	logic [63:0] slot_hi [NUM_PEERS];
	logic [63:0] slot_lo [NUM_PEERS];
	logic [7:0]  slot_range [NUM_PEERS];
	logic [31:0] slot_base [NUM_PEERS];
	logic [31:0] slot_offset [NUM_PEERS];
	logic [31:0] slot_mask [NUM_PEERS];
	logic [31:0] slot_last [NUM_PEERS];

	logic        key_v6 [KEY_POOL];
	logic [63:0] key_hi [KEY_POOL];
	logic [63:0] key_lo [KEY_POOL];

	teid_answer_t pending_answers[$];
	int mismatch_count = 0;
	int answers_checked = 0;
	int requests_sent = 0;
	int full_answers = 0;
	int missed_lookups = 0;
	int refused_allocs = 0;
	bit in_pacing = 0;
	bit out_pacing = 0;
	int out_hold = 0;

	tunnel_id_allocator_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.ip_is_v6(ip_is_v6),
		.addr_hi(addr_hi),
		.addr_lo(addr_lo),
		.range_bits(range_bits),
		.range_value(range_value),
		.pgw_side(pgw_side),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.teid(teid),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#16_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic [31:0] slot_current_id(int s);
		return (slot_last[s] & slot_mask[s]) | (32'(slot_range[s]) << TIAT_RANGE_SHIFT);
	endfunction

	// Applies one request to the shadow table and returns the answer it should give.
	function automatic teid_answer_t peer_table_answer(peer_req_t req);
		teid_answer_t ans;
		int hit;
		int free_slot;
		logic [3:0] rb;
		logic [7:0] rbyte;
		logic serves;
		ans.teid = '0;
		ans.status = TIAT_ST_OK;
		hit = -1;
		free_slot = -1;
		for (int k = 0; k < NUM_PEERS; k++) begin
			if (hit < 0 && slot_used[k] && slot_v6[k] == req.v6) begin
				if (req.v6 ? (slot_hi[k] == req.hi && slot_lo[k] == req.lo)
						: (slot_lo[k][31:0] == req.lo[31:0]))
					hit = k;
			end
			if (free_slot < 0 && !slot_used[k])
				free_slot = k;
		end
		case (req.op)
			TIAT_FUNC_SET_RANGE: begin
				if (hit < 0 && free_slot >= 0) begin
					hit = free_slot;
					slot_used[hit] = 1'b1;
					slot_v6[hit] = req.v6;
					slot_hi[hit] = req.v6 ? req.hi : 64'd0;
					slot_lo[hit] = req.v6 ? req.lo : {32'd0, req.lo[31:0]};
					slot_range[hit] = 8'd0;
					slot_base[hit] = TIAT_FIRST_ID;
					slot_offset[hit] = 32'd0;
					slot_mask[hit] = TIAT_ALL_ONES;
					slot_last[hit] = TIAT_FIRST_ID;
				end
				if (hit < 0) begin
					ans.status = TIAT_ST_FULL;
					full_answers++;
				end else begin
					if (req.rbits != 0) begin
						rb = (req.rbits > TIAT_RANGE_FIELD_BITS) ? TIAT_RANGE_FIELD_BITS
							: req.rbits;
						rbyte = req.rval << (TIAT_RANGE_FIELD_BITS - rb);
						slot_range[hit] = rbyte;
						slot_mask[hit] = TIAT_ALL_ONES >> rb;
						slot_base[hit] = 32'(rbyte) << TIAT_RANGE_SHIFT;
						if (rbyte == 8'd0)
							slot_base[hit] = slot_base[hit] + 32'd1;
					end
					ans.teid = slot_current_id(hit);
				end
			end
			TIAT_FUNC_ALLOCATE: begin
				if (hit < 0) begin
					ans.status = TIAT_ST_NOT_FOUND;
					missed_lookups++;
				end else begin
					serves = req.pgw ? (node_role_model == TIAT_ROLE_PGW)
						: (node_role_model == TIAT_ROLE_SGW
						|| node_role_model == TIAT_ROLE_COMBINED);
					if (serves) begin
						slot_last[hit] = slot_base[hit] + slot_offset[hit];
						if (slot_offset[hit] >= slot_mask[hit])
							slot_offset[hit] = 32'd0;
						else
							slot_offset[hit] = slot_offset[hit] + 32'd1;
					end else begin
						refused_allocs++;
					end
					ans.teid = slot_current_id(hit);
				end
			end
			TIAT_FUNC_DELETE: begin
				if (hit < 0) begin
					ans.status = TIAT_ST_NOT_FOUND;
					missed_lookups++;
				end else begin
					slot_used[hit] = 1'b0;
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	function automatic peer_req_t make_req(tiat_func_t op, logic v6, logic [63:0] hi,
			logic [63:0] lo, logic [3:0] rbits, logic [7:0] rval, logic pgw);
		peer_req_t req;
		req.op = op;
		req.v6 = v6;
		req.hi = hi;
		req.lo = lo;
		req.rbits = rbits;
		req.rval = rval;
		req.pgw = pgw;
		return req;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Keys mostly come from a small pool so that lookups hit; IPv4 keys carry
	// random bits above bit 31, which the block must ignore.
	function automatic peer_req_t random_request(int delete_weight);
		peer_req_t req;
		int k;
		int r;
		k = $urandom_range(0, KEY_POOL - 1);
		req.v6 = key_v6[k];
		req.hi = req.v6 ? key_hi[k] : rand64();
		req.lo = req.v6 ? key_lo[k] : {$urandom(), key_lo[k][31:0]};
		if ($urandom_range(0, 99) < 5) begin
			req.v6 = 1'($urandom_range(0, 1));
			req.hi = rand64();
			req.lo = rand64();
		end
		r = $urandom_range(0, 99);
		if (r < 35)
			req.op = TIAT_FUNC_SET_RANGE;
		else if (r < 35 + delete_weight)
			req.op = TIAT_FUNC_DELETE;
		else if (r < 96)
			req.op = TIAT_FUNC_ALLOCATE;
		else
			req.op = TIAT_FUNC_UNUSED;
		req.rbits = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		req.rval = 8'($urandom_range(0, 255));
		req.pgw = 1'($urandom_range(0, 1));
		return req;
	endfunction

	task automatic send_request(peer_req_t req);
		int gap;
		@(negedge clk);
		gap = (in_pacing && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = req.op;
		ip_is_v6 = req.v6;
		addr_hi = req.hi;
		addr_lo = req.lo;
		range_bits = req.rbits;
		range_value = req.rval;
		pgw_side = req.pgw;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_answers.push_back(peer_table_answer(req));
		requests_sent++;
	endtask

	task automatic wait_for_answers();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (NUM_PEERS + 8) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = ROLE_ADDR;
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_node_role(logic [1:0] role);
		logic [31:0] rd;
		apb_access(1'b1, {30'd0, role}, rd);
		node_role_model = role;
		apb_access(1'b0, 32'd0, rd);
		if (rd[1:0] !== role)
			note_mismatch($sformatf("node role read back %0d, written %0d", rd[1:0], role));
	endtask

	always @(posedge clk) begin
		teid_answer_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				note_mismatch($sformatf("unexpected answer: teid %h status %0d", teid, status));
			end else begin
				exp = pending_answers.pop_front();
				if (teid !== exp.teid || status !== exp.status)
					note_mismatch($sformatf(
						"answer %0d: teid expected %h got %h, status expected %0d got %0d",
						answers_checked, exp.teid, teid, exp.status, status));
				answers_checked++;
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (out_pacing && out_hold > 0) begin
				out_stall = 1'b1;
				out_hold--;
			end else begin
				out_stall = 1'b0;
				if (out_pacing && $urandom_range(0, 3) == 0)
					out_hold = pick_gap();
			end
		end
	end

	task automatic test_register_access();
		set_node_role(TIAT_ROLE_COMBINED);
		set_node_role(TIAT_ROLE_PGW);
		set_node_role(ROLE_NONE);
		set_node_role(TIAT_ROLE_SGW);
	endtask

	task automatic test_basic_operations();
		logic [63:0] ones;
		ones = '1;
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_DELETE, 1'b1, ones, ones, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_UNUSED, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_SET_RANGE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, ones, {32'hFFFF_FFFF, 32'd0},
			4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_SET_RANGE, 1'b0, 64'd0, 64'd0, 4'd8, 8'hFF, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		// Serving-side role does not hand out packet-gateway IDs.
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b1));
		// An IPv6 key whose bits equal an IPv4 key is a different peer.
		send_request(make_req(TIAT_FUNC_SET_RANGE, 1'b1, 64'd0, 64'd0, 4'd15, 8'hAA, 1'b0));
		send_request(make_req(TIAT_FUNC_SET_RANGE, 1'b0, ones, ones, 4'd1, 8'd0, 1'b1));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, {32'd0, 32'hFFFF_FFFF},
			4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_SET_RANGE, 1'b1, ones, ones, 4'd4, 8'h0F, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b1, ones, ones, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_DELETE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b1, 64'd0, 64'd0, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_UNUSED, 1'b1, ones, ones, 4'd8, 8'h55, 1'b1));
		wait_for_answers();
		set_node_role(TIAT_ROLE_PGW);
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b1, ones, ones, 4'd0, 8'd0, 1'b1));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b1, ones, ones, 4'd0, 8'd0, 1'b0));
		wait_for_answers();
	endtask

	task automatic test_table_capacity();
		logic [63:0] lo;
		for (int n = 0; n < 14; n++) begin
			lo = {32'd0, 32'h0A00_0000 + 32'(n)};
			send_request(make_req(TIAT_FUNC_SET_RANGE, n[0], 64'h2001_0DB8_0000_0000, lo,
				4'(n % 9), 8'(n * 37), 1'b0));
		end
		// Free a slot in the middle; the next new peer must land there.
		send_request(make_req(TIAT_FUNC_DELETE, 1'b0, 64'h2001_0DB8_0000_0000,
			64'h0A00_0004, 4'd0, 8'd0, 1'b0));
		send_request(make_req(TIAT_FUNC_SET_RANGE, 1'b0, 64'd0, 64'h0B00_0001,
			4'd3, 8'h07, 1'b0));
		send_request(make_req(TIAT_FUNC_ALLOCATE, 1'b0, 64'd0, 64'h0B00_0001,
			4'd0, 8'd0, 1'b1));
		wait_for_answers();
	endtask

	task automatic test_random_traffic();
		logic [1:0] roles [6];
		roles = '{TIAT_ROLE_SGW, TIAT_ROLE_PGW, TIAT_ROLE_COMBINED, ROLE_NONE,
			TIAT_ROLE_PGW, TIAT_ROLE_SGW};
		for (int i = 0; i < KEY_POOL; i++) begin
			key_v6[i] = i[0];
			key_hi[i] = rand64();
			key_lo[i] = rand64();
			if (i % 4 == 3) begin
				key_hi[i] = 64'd0;
				key_lo[i] = {32'd0, key_lo[i-1][31:0]};
			end
		end
		for (int ph = 0; ph < 6; ph++) begin
			set_node_role(roles[ph]);
			in_pacing = (ph != 2);
			out_pacing = (ph != 2);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request(ph[0] ? 20 : 8));
			wait_for_answers();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = TIAT_FUNC_SET_RANGE;
		ip_is_v6 = 1'b0;
		addr_hi = '0;
		addr_lo = '0;
		range_bits = '0;
		range_value = '0;
		pgw_side = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		node_role_model = TIAT_ROLE_SGW;
		for (int k = 0; k < NUM_PEERS; k++)
			slot_used[k] = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_basic_operations();
		test_table_capacity();
		test_random_traffic();
		wait_for_answers();

		$display("Covered %0d requests under all four role codes; %0d answers checked.",
			requests_sent, answers_checked);
		$display("Seen %0d table-full answers, %0d missed lookups, %0d refused allocations.",
			full_answers, missed_lookups, refused_allocs);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/tiat_pkg.sv
design/tiat_ram.sv
design/tunnel_id_allocator_table.sv
bench/tb_tunnel_id_allocator_table.sv
